// ----- sv/pte_pkg.sv -----
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types and codes for the peer table engine: item layouts, opcodes,
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pte_pkg;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_LOOKUP     = 3'd2,
    OP_SET_RSSI   = 3'd3,
    OP_MARK_SEEN  = 3'd4,
    OP_AVERAGE    = 3'd5
  } pte_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } pte_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_MODIFY,
    S_SWEEP,
    S_DIVSET,
    S_DIV,
    S_AVGOUT
  } pte_state_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [7:0]        node_id;
    logic [31:0]       ip_addr;
    logic [15:0]       port;
    logic signed [7:0] rssi;
    logic [31:0]       now_ms;
  } pte_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        out_node_id;
    logic [31:0]       out_ip_addr;
    logic [15:0]       out_port;
    logic signed [7:0] out_rssi;
    logic [31:0]       out_last_seen;
    logic              out_alive;
    logic signed [7:0] mean_rssi;
  } pte_res_t;

  // one slot's payload as kept in the RAM
  typedef struct packed {
    logic [31:0] ip_addr;
    logic [15:0] port;
    logic [7:0]  rssi;
    logic [31:0] seen;
  } pte_word_t;

  typedef struct packed {
    logic load;
    logic search;
    logic decide;
    logic modify;
    logic sweep_start;
    logic sweep;
    logic div_start;
    logic div_step;
    logic finish;
  } pte_cmd_t;

  typedef struct packed {
    logic is_avg;
    logic need_modify;
    logic sweep_done;
    logic div_done;
  } pte_sts_t;

endpackage

// ----- sv/pte_ram.sv -----
// ----------------------------------------------------------------------------
// pte_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/pte_ctrl.sv -----
// ----------------------------------------------------------------------------
// pte_ctrl
// Sequencer for the peer table engine: steps each item through search,
// decide and modify, or through the strength sweep and the divider.
// ----------------------------------------------------------------------------
module pte_ctrl
  import pte_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  pte_sts_t sts_i,
  output pte_cmd_t cmd_o
);

  pte_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.is_avg) begin
          cmd_o.sweep_start = 1'b1;
          state_d           = S_SWEEP;
        end else if (sts_i.need_modify) begin
          state_d = S_MODIFY;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_MODIFY: begin
        cmd_o.modify = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = S_DIVSET;
        end
      end
      S_DIVSET: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_AVGOUT;
        end
      end
      S_AVGOUT: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- sv/pte_dp.sv -----
// ----------------------------------------------------------------------------
// pte_dp
// Datapath of the peer table engine: key compare array, slot RAM,
// strength accumulator, restoring divider and result register.
// ----------------------------------------------------------------------------
module pte_dp
  import pte_pkg::*;
#(
  parameter int PeerSlots = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pte_req_t req_i,
  input  pte_cmd_t cmd_i,
  output pte_sts_t sts_o,
  output logic     res_valid_o,
  output pte_res_t res_o
);

  localparam int SlotW = $clog2(PeerSlots);
  localparam int CntW  = $clog2(PeerSlots + 1);
  localparam int SumW  = SlotW + 9;
  localparam int MagW  = SumW - 1;
  localparam int DcW   = $clog2(MagW);
  localparam int WordW = $bits(pte_word_t);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(PeerSlots - 1);

  pte_req_t        req_q;
  pte_op_e         op;
  logic [PeerSlots-1:0] valid_q;
  logic [7:0]      node_q [PeerSlots];

  logic            hit_c, free_c;
  logic [SlotW-1:0] hit_idx_c, free_idx_c;
  logic            hit_q, free_q;
  logic [SlotW-1:0] hit_idx_q, free_idx_q;

  logic            ram_we;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  pte_word_t       ram_wdata, ram_rdata;
  logic [WordW-1:0] ram_rdata_raw;

  logic            new_reg, need_modify;

  logic [SlotW-1:0] swp_idx_q, acc_idx_q;
  logic            swp_end_q, acc_vld_q;
  logic signed [SumW-1:0] total_q;
  logic [CntW-1:0] count_q;

  logic            neg_q;
  logic [MagW-1:0] quo_q;
  logic [CntW-1:0] rem_q;
  logic [DcW-1:0]  dcnt_q;
  logic [SumW-1:0] mag_c;
  logic [CntW:0]   trial_c;
  logic            fits_c;
  logic [7:0]      mean_c;

  pte_status_e     status_c;
  pte_res_t        res_c;
  pte_res_t        res_q;
  logic            res_valid_q;

  assign op = pte_op_e'(req_q.opcode);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // parallel key compare; lowest index wins
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = PeerSlots - 1; i >= 0; i--) begin
      if (valid_q[i] && node_q[i] == req_q.node_id) begin
        hit_c     = 1'b1;
        hit_idx_c = SlotW'(i);
      end
      if (!valid_q[i]) begin
        free_c     = 1'b1;
        free_idx_c = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      hit_q      <= hit_c;
      free_q     <= free_c;
      hit_idx_q  <= hit_idx_c;
      free_idx_q <= free_idx_c;
    end
  end

  assign new_reg = (op == OP_REGISTER) && (req_q.node_id != 8'd0) && !hit_q && free_q;
  assign need_modify = hit_q && ((op == OP_REGISTER) || (op == OP_LOOKUP) ||
                                 (op == OP_SET_RSSI) || (op == OP_MARK_SEEN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.decide) begin
      if (new_reg) begin
        valid_q[free_idx_q] <= 1'b1;
      end else if (op == OP_UNREGISTER && hit_q) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && new_reg) begin
      node_q[free_idx_q] <= req_q.node_id;
    end
  end

  // slot RAM write: fresh entry on decide, read-modify-write on modify
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx_q;
    ram_wdata = ram_rdata;
    if (cmd_i.decide && new_reg) begin
      ram_we    = 1'b1;
      ram_wdata = '{ip_addr: req_q.ip_addr, port: req_q.port, rssi: 8'd0,
                    seen: req_q.now_ms};
    end else if (cmd_i.modify && op != OP_LOOKUP) begin
      ram_we    = 1'b1;
      ram_waddr = hit_idx_q;
      case (op)
        OP_REGISTER: begin
          ram_wdata.ip_addr = req_q.ip_addr;
          ram_wdata.port    = req_q.port;
          ram_wdata.seen    = req_q.now_ms;
        end
        OP_SET_RSSI:  ram_wdata.rssi = req_q.rssi;
        OP_MARK_SEEN: ram_wdata.seen = req_q.now_ms;
        default:      ram_we = 1'b0;
      endcase
    end
  end

  assign ram_raddr = cmd_i.sweep ? swp_idx_q : hit_idx_q;
  assign ram_rdata = pte_word_t'(ram_rdata_raw);

  pte_ram #(
    .Width (WordW),
    .Depth (PeerSlots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  // strength sweep: one read issued per cycle, its data accumulated in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
      swp_end_q <= 1'b0;
      swp_idx_q <= '0;
    end else begin
      acc_vld_q <= !cmd_i.sweep_start && cmd_i.sweep && !swp_end_q;
      if (cmd_i.sweep_start) begin
        swp_idx_q <= '0;
        swp_end_q <= 1'b0;
      end else if (cmd_i.sweep && !swp_end_q) begin
        if (swp_idx_q == LastSlot) begin
          swp_end_q <= 1'b1;
        end else begin
          swp_idx_q <= swp_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep && !swp_end_q) begin
      acc_idx_q <= swp_idx_q;
    end
    if (cmd_i.sweep_start) begin
      total_q <= '0;
      count_q <= '0;
    end else if (acc_vld_q && valid_q[acc_idx_q] && ram_rdata.rssi != 8'd0) begin
      total_q <= total_q + {{(SumW-8){ram_rdata.rssi[7]}}, ram_rdata.rssi};
      count_q <= count_q + 1'b1;
    end
  end

  // restoring division of |total| by count, one quotient bit per cycle
  assign mag_c   = total_q[SumW-1] ? SumW'(-total_q) : SumW'(total_q);
  assign trial_c = {rem_q, quo_q[MagW-1]};
  assign fits_c  = (trial_c >= {1'b0, count_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q  <= total_q[SumW-1];
      quo_q  <= mag_c[MagW-1:0];
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[MagW-2:0], fits_c};
      rem_q  <= fits_c ? CntW'(trial_c - {1'b0, count_q}) : trial_c[CntW-1:0];
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  assign mean_c = (count_q == '0) ? 8'd0 :
                  neg_q ? 8'(-quo_q[7:0]) : quo_q[7:0];

  always_comb begin
    status_c = ST_OK;
    case (op)
      OP_REGISTER: begin
        if (req_q.node_id == 8'd0) status_c = ST_BAD_ID;
        else if (!hit_q && !free_q) status_c = ST_FULL;
      end
      OP_UNREGISTER, OP_LOOKUP, OP_SET_RSSI, OP_MARK_SEEN: begin
        if (!hit_q) status_c = ST_NOT_FOUND;
      end
      default: status_c = ST_OK;
    endcase
  end

  always_comb begin
    res_c        = '0;
    res_c.status = status_c;
    if (op == OP_LOOKUP && hit_q) begin
      res_c.out_node_id   = req_q.node_id;
      res_c.out_ip_addr   = ram_rdata.ip_addr;
      res_c.out_port      = ram_rdata.port;
      res_c.out_rssi      = ram_rdata.rssi;
      res_c.out_last_seen = ram_rdata.seen;
      res_c.out_alive     = 1'b1;
    end
    if (op == OP_AVERAGE) begin
      res_c.mean_rssi = mean_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q <= res_c;
    end
  end

  assign sts_o.is_avg      = (op == OP_AVERAGE);
  assign sts_o.need_modify = need_modify;
  assign sts_o.sweep_done  = acc_vld_q && (acc_idx_q == LastSlot);
  assign sts_o.div_done    = (dcnt_q == DcW'(MagW - 1));

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/peer_table_engine_unit.sv -----
// ----------------------------------------------------------------------------
// peer_table_engine_unit
// Associative peer table keyed by node id, with register, unregister,
// lookup, strength update, mark seen and average strength operations.
// ----------------------------------------------------------------------------
// Issue an item by raising start while busy is low; the item is taken at that
// clock edge and busy stays high until the block can take the next one. Each
// item yields exactly one result, shown on res_o for one cycle with res_valid_o
// high; the receiver must take it then, as it cannot be held. Register, lookup,
// set strength and mark seen on a known id run a key compare, then a read of
// the slot RAM and, but for lookup, a write back; every other item except
// average finishes with the key compare and the decision. Average strength
// reads the slot RAM once per slot, then runs a one-bit-per-cycle divider.
// Valid bits clear at reset; no clearing pass is needed.
module peer_table_engine_unit
  import pte_pkg::*;
#(
  parameter int PEER_SLOTS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  pte_req_t req_i,
  output logic     res_valid_o,
  output pte_res_t res_o
);

  pte_cmd_t cmd;
  pte_sts_t sts;

  pte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pte_dp #(
    .PeerSlots (PEER_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without an item in flight");

  a_alive_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_alive |-> res_o.status == ST_OK)
    else $error("found entry reported with error status");
`endif

endmodule

// ----- dv/tb_peer_table_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peer_table_engine_unit
// Self-checking bench for the peer table engine. A behavioral table model
// predicts each result as its item is taken. Directed items cover register
// edge cases, a full table, truncated averages and unused opcodes. Random
// traffic on a small id pool follows, under three sender idle rates.
// ----------------------------------------------------------------------------
module tb_peer_table_engine_unit;
  import pte_pkg::*;

  localparam int PEER_SLOTS = 16;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam int MAX_REPORTS = 100;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  pte_req_t cmd_item = '0;
  logic     res_valid;
  pte_res_t res_item;

  // table model
  logic              peer_valid [PEER_SLOTS];
  logic [7:0]        peer_id    [PEER_SLOTS];
  logic [31:0]       peer_ip    [PEER_SLOTS];
  logic [15:0]       peer_port  [PEER_SLOTS];
  logic signed [7:0] peer_rssi  [PEER_SLOTS];
  logic [31:0]       peer_seen  [PEER_SLOTS];

  pte_res_t pending_results [$];
  int       error_count = 0;
  int       result_count = 0;

  peer_table_engine_unit #(
    .PEER_SLOTS(PEER_SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (cmd_item),
    .res_valid_o(res_valid),
    .res_o      (res_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("peer_table_engine_unit regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                result_count, name, got, want));
    end
  endtask

  function automatic pte_req_t make_item(input logic [2:0] op, input logic [7:0] id,
                                         input logic [31:0] ip, input logic [15:0] port,
                                         input logic [7:0] rssi, input logic [31:0] now);
    pte_req_t item;
    item.opcode  = op;
    item.node_id = id;
    item.ip_addr = ip;
    item.port    = port;
    item.rssi    = rssi;
    item.now_ms  = now;
    return item;
  endfunction

  // Applies one operation to the model table and returns its result.
  function automatic pte_res_t predict_peer_op(input pte_req_t item);
    pte_res_t res;
    int       hit;
    int       free_slot;
    int       total;
    int       count;
    int       i;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    free_slot = -1;
    total = 0;
    count = 0;
    // scan downward so the lowest-numbered slot wins
    for (i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (peer_valid[i] && peer_id[i] == item.node_id) hit = i;
      if (!peer_valid[i]) free_slot = i;
    end
    case (item.opcode)
      OP_REGISTER: begin
        if (item.node_id == 8'd0) begin
          res.status = ST_BAD_ID;
        end else if (hit >= 0) begin
          peer_ip[hit]   = item.ip_addr;
          peer_port[hit] = item.port;
          peer_seen[hit] = item.now_ms;
        end else if (free_slot >= 0) begin
          peer_valid[free_slot] = 1'b1;
          peer_id[free_slot]    = item.node_id;
          peer_ip[free_slot]    = item.ip_addr;
          peer_port[free_slot]  = item.port;
          peer_rssi[free_slot]  = '0;
          peer_seen[free_slot]  = item.now_ms;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_UNREGISTER: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else peer_valid[hit] = 1'b0;
      end
      OP_LOOKUP: begin
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.out_node_id   = peer_id[hit];
          res.out_ip_addr   = peer_ip[hit];
          res.out_port      = peer_port[hit];
          res.out_rssi      = peer_rssi[hit];
          res.out_last_seen = peer_seen[hit];
          res.out_alive     = 1'b1;
        end
      end
      OP_SET_RSSI: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else peer_rssi[hit] = item.rssi;
      end
      OP_MARK_SEEN: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else peer_seen[hit] = item.now_ms;
      end
      OP_AVERAGE: begin
        for (i = 0; i < PEER_SLOTS; i++) begin
          if (peer_valid[i] && peer_rssi[i] != 0) begin
            total += peer_rssi[i];
            count++;
          end
        end
        // int division truncates toward zero
        if (count > 0) res.mean_rssi = 8'(total / count);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Called at a rising edge. Leaves start high on return so a following
  // item can go out back to back; callers that pause lower it first.
  task automatic issue_item(input pte_req_t item, input int idle_pct);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start    <= 1'b1;
    cmd_item <= item;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_peer_op(item));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    pte_res_t want;
    if (rst_ni && res_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item pending",
                                  result_count));
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 32'(res_item.status), 32'(want.status));
        compare_field("out_node_id", 32'(res_item.out_node_id),
                      32'(want.out_node_id));
        compare_field("out_ip_addr", res_item.out_ip_addr, want.out_ip_addr);
        compare_field("out_port", 32'(res_item.out_port), 32'(want.out_port));
        compare_field("out_rssi", 32'(res_item.out_rssi), 32'(want.out_rssi));
        compare_field("out_last_seen", res_item.out_last_seen, want.out_last_seen);
        compare_field("out_alive", 32'(res_item.out_alive), 32'(want.out_alive));
        compare_field("mean_rssi", 32'(res_item.mean_rssi), 32'(want.mean_rssi));
      end
      result_count++;
    end
  end

  task automatic test_basic_ops();
    issue_item(make_item(OP_AVERAGE, 8'd9, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
    issue_item(make_item(OP_REGISTER, 8'd0, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
    issue_item(make_item(OP_REGISTER, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'h7F,
                         32'hFFFF_FFFF), 0);
    issue_item(make_item(OP_SET_RSSI, 8'hFF, 32'd0, 16'd0, 8'h7F, 32'd0), 0);
    // update in place: strength must survive
    issue_item(make_item(OP_REGISTER, 8'hFF, 32'h0, 16'h0, 8'h80, 32'h1234), 0);
    issue_item(make_item(OP_LOOKUP, 8'hFF, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
    issue_item(make_item(OP_MARK_SEEN, 8'hFF, $urandom, 16'($urandom), 8'($urandom),
                         32'd0), 0);
    issue_item(make_item(OP_LOOKUP, 8'hFF, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
    issue_item(make_item(OP_LOOKUP, 8'd0, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
    issue_item(make_item(OP_UNREGISTER, 8'd7, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
  endtask

  task automatic test_table_full();
    int n;
    for (n = 1; n < PEER_SLOTS; n++) begin
      issue_item(make_item(OP_REGISTER, 8'(n), $urandom, 16'($urandom), 8'($urandom),
                           $urandom), 0);
    end
    issue_item(make_item(OP_REGISTER, 8'(PEER_SLOTS), $urandom, 16'($urandom),
                         8'($urandom), $urandom), 0);
    // (127 - 128) / 2 truncates to zero, then (127 - 128 - 3) / 3 to -1
    issue_item(make_item(OP_SET_RSSI, 8'd1, 32'd0, 16'd0, 8'h80, 32'd0), 0);
    issue_item(make_item(OP_AVERAGE, 8'd0, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
    issue_item(make_item(OP_SET_RSSI, 8'd2, 32'd0, 16'd0, 8'hFD, 32'd0), 0);
    issue_item(make_item(OP_AVERAGE, 8'd0, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
  endtask

  task automatic test_unused_ops();
    issue_item(make_item(OP_UNUSED_6, 8'd1, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
    issue_item(make_item(OP_UNUSED_7, 8'hFF, $urandom, 16'($urandom), 8'($urandom),
                         $urandom), 0);
  endtask

  function automatic logic [7:0] pick_node_id();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 8'd0;
    if (r < 12) return 8'($urandom_range(255));
    return 8'($urandom_range(24, 1));
  endfunction

  // Mostly registers and operations on a small id pool so entries are hit,
  // updated and the table fills and drains.
  task automatic test_random_traffic(input int num_items, input int idle_pct);
    pte_req_t item;
    int       r;
    int       n;
    for (n = 0; n < num_items; n++) begin
      r = $urandom_range(99);
      item = make_item(OP_REGISTER, pick_node_id(), $urandom, 16'($urandom),
                       8'($urandom), $urandom);
      if (r >= 30) item.opcode = OP_UNREGISTER;
      if (r >= 42) item.opcode = OP_LOOKUP;
      if (r >= 62) item.opcode = OP_SET_RSSI;
      if (r >= 78) item.opcode = OP_MARK_SEEN;
      if (r >= 90) item.opcode = OP_AVERAGE;
      if ($urandom_range(99) < 15) item.rssi = '0;
      issue_item(item, idle_pct);
    end
  endtask

  initial begin
    foreach (peer_valid[i]) peer_valid[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_table_full();
    test_unused_ops();
    wait_for_results();
    test_random_traffic(170, 31);
    wait_for_results();
    test_random_traffic(170, 72);
    wait_for_results();
    test_random_traffic(160, 0);
    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("peer_table_engine_unit regression: pass");
    end else begin
      $display("peer_table_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
